// ===== rtl/eul_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to
// rotation matrix block. No dependencies.
package eul_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int WORK_FRAC    = 30;

    typedef logic signed [33:0] cordic_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [32:0] sum_t;

    typedef struct packed {
        trig_t cos_v;
        trig_t sin_v;
    } sincos_t;

    localparam cordic_t CORDIC_START = 34'sh026DD3B6A;

    // Arctangent of 2^-i in phase units, where 2^32 is one full turn.
    function automatic cordic_t atan_phase(input int i);
        cordic_t r;
        unique case (i)
            0:  r = 34'sh020000000;
            1:  r = 34'sh012E4051D;
            2:  r = 34'sh009FB385B;
            3:  r = 34'sh0051111D4;
            4:  r = 34'sh0028B0D43;
            5:  r = 34'sh00145D7E1;
            6:  r = 34'sh000A2F61E;
            7:  r = 34'sh000517C55;
            8:  r = 34'sh00028BE53;
            9:  r = 34'sh000145F2E;
            10: r = 34'sh0000A2F98;
            11: r = 34'sh0000517CC;
            12: r = 34'sh000028BE6;
            13: r = 34'sh0000145F3;
            14: r = 34'sh00000A2F9;
            15: r = 34'sh00000517C;
            16: r = 34'sh0000028BE;
            17: r = 34'sh00000145F;
            18: r = 34'sh000000A2F;
            19: r = 34'sh000000517;
            20: r = 34'sh00000028B;
            21: r = 34'sh000000145;
            22: r = 34'sh0000000A2;
            23: r = 34'sh000000051;
            24: r = 34'sh000000028;
            25: r = 34'sh000000014;
            26: r = 34'sh00000000A;
            27: r = 34'sh000000005;
            28: r = 34'sh000000002;
            29: r = 34'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q30 by Q30 product, rounded to nearest back to Q30.
    function automatic trig_t qmul(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        p = p >>> WORK_FRAC;
        return p[31:0];
    endfunction

endpackage

// ===== rtl/eul_cordic.sv =====
// Pipelined rotation-mode CORDIC: one binary angle to cosine and sine in Q30.
// Uses eul_pkg for the arctangent table and types.
module eul_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [15:0]   angle,
    output eul_pkg::sincos_t     result
);

    localparam int N = eul_pkg::CORDIC_STEPS;

    logic [31:0] ext;
    logic [31:0] phase;

    eul_pkg::cordic_t x_in [0:N-1];
    eul_pkg::cordic_t y_in [0:N-1];
    eul_pkg::cordic_t z_in [0:N-1];
    logic [1:0]       q_in [0:N-1];

    eul_pkg::cordic_t x_reg [0:N-1];
    eul_pkg::cordic_t y_reg [0:N-1];
    eul_pkg::cordic_t z_reg [0:N-1];
    logic [1:0]       q_reg [0:N-1];

    eul_pkg::cordic_t xf;
    eul_pkg::cordic_t yf;
    eul_pkg::cordic_t nxf;
    eul_pkg::cordic_t nyf;

    // Only the low ANGLE_BITS of the sign-extended field count as the angle.
    assign ext   = {{16{angle[15]}}, angle};
    assign phase = ext << (32 - ANGLE_BITS);

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_step
            if (i == 0) begin : g_first
                assign x_in[i] = eul_pkg::CORDIC_START;
                assign y_in[i] = '0;
                assign z_in[i] = {4'b0000, phase[29:0]};
                assign q_in[i] = phase[31:30];
            end else begin : g_next
                assign x_in[i] = x_reg[i-1];
                assign y_in[i] = y_reg[i-1];
                assign z_in[i] = z_reg[i-1];
                assign q_in[i] = q_reg[i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_in[i] >= 0)
                    begin
                        x_reg[i] <= x_in[i] - (y_in[i] >>> i);
                        y_reg[i] <= y_in[i] + (x_in[i] >>> i);
                        z_reg[i] <= z_in[i] - eul_pkg::atan_phase(i);
                    end
                    else
                    begin
                        x_reg[i] <= x_in[i] + (y_in[i] >>> i);
                        y_reg[i] <= y_in[i] - (x_in[i] >>> i);
                        z_reg[i] <= z_in[i] + eul_pkg::atan_phase(i);
                    end
                    q_reg[i] <= q_in[i];
                end
            end
        end
    endgenerate

    assign xf  = x_reg[N-1];
    assign yf  = y_reg[N-1];
    assign nxf = -xf;
    assign nyf = -yf;

    // The quadrant is folded in exactly by swapping and negating.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[N-1])
                2'd0:
                begin
                    result.cos_v <= xf[31:0];
                    result.sin_v <= yf[31:0];
                end
                2'd1:
                begin
                    result.cos_v <= nyf[31:0];
                    result.sin_v <= xf[31:0];
                end
                2'd2:
                begin
                    result.cos_v <= nxf[31:0];
                    result.sin_v <= nyf[31:0];
                end
                default:
                begin
                    result.cos_v <= yf[31:0];
                    result.sin_v <= nxf[31:0];
                end
            endcase
        end
    end

endmodule

// ===== rtl/euler_to_rotation_matrix.sv =====
// Throughput: one beat per cycle while the output is not stalled; the path
// is a 30-stage CORDIC per angle, a quadrant stage, two multiply stages, a
// sum stage and a rounding stage.
// A stall at the output holds every stage; the input stalls only then.
// Reset (rst_n low, asynchronous) clears all valid bits and mode_reg to 0.
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS        = 16,
    parameter int ELEMENT_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] second_angle,
    input  logic signed [15:0] third_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    localparam int LAT = eul_pkg::CORDIC_STEPS + 5;
    localparam int SH  = eul_pkg::WORK_FRAC - ELEMENT_FRAC_BITS;
    localparam logic signed [34:0] RND = (SH > 0) ? (35'sd1 <<< ((SH > 0) ? SH - 1 : 0))
                                                  : 35'sd0;
    localparam logic signed [34:0] LIM = 35'sd1 <<< ELEMENT_FRAC_BITS;

    logic           mode_reg;
    logic [LAT-1:0] vld_reg;
    logic           ce;

    eul_pkg::sincos_t sc_a;
    eul_pkg::sincos_t sc_b;
    eul_pkg::sincos_t sc_c;

    eul_pkg::trig_t p1_reg [0:9];
    eul_pkg::trig_t ca1_reg;
    eul_pkg::trig_t sa1_reg;
    eul_pkg::trig_t sb1_reg;

    eul_pkg::trig_t p2_reg [0:9];
    eul_pkg::trig_t q2_reg [0:3];
    eul_pkg::trig_t sb2_reg;

    eul_pkg::sum_t  m3_reg [0:8];
    eul_pkg::sum_t  m3_next [0:8];
    logic [15:0]    out_reg [0:8];

    function automatic logic [15:0] to_field(input eul_pkg::sum_t v);
        logic signed [34:0] w;
        w = 35'(v);
        if (SH > 0)
            w = (w + RND) >>> SH;
        if (w > LIM)
            w = LIM;
        if (w < -LIM)
            w = -LIM;
        return w[15:0];
    endfunction

    assign ce        = !(out_valid && out_stall);
    assign in_stall  = !ce;
    assign out_valid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                mode_reg <= cfg_data;
            if (ce)
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    eul_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_a (
        .clk(clk), .en(ce), .angle(yaw_angle), .result(sc_a)
    );
    eul_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_b (
        .clk(clk), .en(ce), .angle(second_angle), .result(sc_b)
    );
    eul_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_c (
        .clk(clk), .en(ce), .angle(third_angle), .result(sc_c)
    );

    // First products. Slot meaning depends on the product order.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ca1_reg <= sc_a.cos_v;
            sa1_reg <= sc_a.sin_v;
            sb1_reg <= sc_b.sin_v;
            if (!mode_reg)
            begin
                p1_reg[0] <= eul_pkg::qmul(sc_c.cos_v, sc_a.cos_v);
                p1_reg[1] <= eul_pkg::qmul(sc_c.cos_v, sc_a.sin_v);
                p1_reg[2] <= eul_pkg::qmul(sc_c.sin_v, sc_a.cos_v);
                p1_reg[3] <= eul_pkg::qmul(sc_c.sin_v, sc_a.sin_v);
                p1_reg[4] <= eul_pkg::qmul(sc_b.cos_v, sc_a.cos_v);
                p1_reg[5] <= eul_pkg::qmul(sc_b.cos_v, sc_a.sin_v);
                p1_reg[6] <= eul_pkg::qmul(sc_b.cos_v, sc_c.sin_v);
                p1_reg[7] <= eul_pkg::qmul(sc_b.cos_v, sc_c.cos_v);
                p1_reg[8] <= '0;
                p1_reg[9] <= '0;
            end
            else
            begin
                p1_reg[0] <= eul_pkg::qmul(sc_b.sin_v, sc_c.sin_v);
                p1_reg[1] <= eul_pkg::qmul(sc_b.sin_v, sc_c.cos_v);
                p1_reg[2] <= eul_pkg::qmul(sc_a.cos_v, sc_c.cos_v);
                p1_reg[3] <= eul_pkg::qmul(sc_a.sin_v, sc_b.cos_v);
                p1_reg[4] <= eul_pkg::qmul(sc_a.cos_v, sc_c.sin_v);
                p1_reg[5] <= eul_pkg::qmul(sc_a.sin_v, sc_c.cos_v);
                p1_reg[6] <= eul_pkg::qmul(sc_a.cos_v, sc_b.cos_v);
                p1_reg[7] <= eul_pkg::qmul(sc_a.sin_v, sc_c.sin_v);
                p1_reg[8] <= eul_pkg::qmul(sc_b.cos_v, sc_c.sin_v);
                p1_reg[9] <= eul_pkg::qmul(sc_b.cos_v, sc_c.cos_v);
            end
        end
    end

    // Second products on the first-level terms.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p2_reg  <= p1_reg;
            sb2_reg <= sb1_reg;
            if (!mode_reg)
            begin
                q2_reg[0] <= eul_pkg::qmul(sb1_reg, p1_reg[2]);
                q2_reg[1] <= eul_pkg::qmul(sb1_reg, p1_reg[0]);
                q2_reg[2] <= eul_pkg::qmul(sb1_reg, p1_reg[3]);
                q2_reg[3] <= eul_pkg::qmul(sb1_reg, p1_reg[1]);
            end
            else
            begin
                q2_reg[0] <= eul_pkg::qmul(sa1_reg, p1_reg[0]);
                q2_reg[1] <= eul_pkg::qmul(sa1_reg, p1_reg[1]);
                q2_reg[2] <= eul_pkg::qmul(ca1_reg, p1_reg[0]);
                q2_reg[3] <= eul_pkg::qmul(ca1_reg, p1_reg[1]);
            end
        end
    end

    always_comb
    begin
        if (!mode_reg)
        begin
            m3_next[0] = 33'(p2_reg[4]);
            m3_next[1] = 33'(q2_reg[0]) - 33'(p2_reg[1]);
            m3_next[2] = 33'(q2_reg[1]) + 33'(p2_reg[3]);
            m3_next[3] = 33'(p2_reg[5]);
            m3_next[4] = 33'(q2_reg[2]) + 33'(p2_reg[0]);
            m3_next[5] = 33'(q2_reg[3]) - 33'(p2_reg[2]);
            m3_next[6] = -33'(sb2_reg);
            m3_next[7] = 33'(p2_reg[6]);
            m3_next[8] = 33'(p2_reg[7]);
        end
        else
        begin
            m3_next[0] = 33'(p2_reg[2]) - 33'(q2_reg[0]);
            m3_next[1] = -33'(p2_reg[3]);
            m3_next[2] = 33'(p2_reg[4]) + 33'(q2_reg[1]);
            m3_next[3] = 33'(p2_reg[5]) + 33'(q2_reg[2]);
            m3_next[4] = 33'(p2_reg[6]);
            m3_next[5] = 33'(p2_reg[7]) - 33'(q2_reg[3]);
            m3_next[6] = -33'(p2_reg[8]);
            m3_next[7] = 33'(sb2_reg);
            m3_next[8] = 33'(p2_reg[9]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m3_reg <= m3_next;
            for (int k = 0; k < 9; k++)
                out_reg[k] <= to_field(m3_reg[k]);
        end
    end

    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m02 = out_reg[2];
    assign m10 = out_reg[3];
    assign m11 = out_reg[4];
    assign m12 = out_reg[5];
    assign m20 = out_reg[6];
    assign m21 = out_reg[7];
    assign m22 = out_reg[8];

endmodule

// ===== rtl/eul_checker.sv =====
// Port-level checks for euler_to_rotation_matrix, attached by bind.
// Depends only on the top level's ports.
module eul_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] m00,
    input logic signed [15:0] m22
);

    // A stalled output beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // The input stalls only behind a stalled output beat.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Entries saturate at plus or minus one.
    a_range00: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> m00 <= 16'sd16384 && m00 >= -16'sd16384)
        else $error("m00 out of range");

    a_range22: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> m22 <= 16'sd16384 && m22 >= -16'sd16384)
        else $error("m22 out of range");

endmodule

bind euler_to_rotation_matrix eul_checker u_eul_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .m00(m00), .m22(m22)
);
